@@ rtl/core/pbtd_pkg.sv @@
// Shared types, constants and character decode functions for the base text decoder.
package pbtd_pkg;

  localparam int PBTD_QDEPTH = 4;

  localparam logic [6:0] VAL_PAD = 7'd64;
  localparam logic [6:0] VAL_BAD = 7'd65;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_PREFIX      = 3'd1,
    ERR_CHAR        = 3'd2,
    ERR_MISSING_PAD = 3'd3,
    ERR_EXTRA_PAD   = 3'd4,
    ERR_AFTER_PAD   = 3'd5,
    ERR_UNUSED      = 3'd6
  } err_t;

  // One request's worth of results: bytes top-aligned, then an optional status.
  typedef struct packed {
    logic [39:0] bytes;
    logic [2:0]  nbytes;
    logic        has_status;
    err_t        err;
  } bundle_t;

  function automatic logic [2:0] char_bits(input logic [2:0] base);
    logic [2:0] r;
    if (base[2]) r = 3'd6;
    else if (base[1]) r = 3'd5;
    else r = 3'd4;
    return r;
  endfunction

  function automatic logic [3:0] group_len(input logic [2:0] base);
    logic [3:0] r;
    if (base[2]) r = 4'd4;
    else if (base[1]) r = 4'd8;
    else r = 4'd2;
    return r;
  endfunction

  function automatic logic is_padded(input logic [2:0] base);
    return base[2] & base[0];
  endfunction

  // {found, base index}
  function automatic logic [3:0] prefix_decode(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      "f":     r = 4'b1_000;
      "F":     r = 4'b1_001;
      "b":     r = 4'b1_010;
      "B":     r = 4'b1_011;
      "m":     r = 4'b1_100;
      "M":     r = 4'b1_101;
      "u":     r = 4'b1_110;
      "U":     r = 4'b1_111;
      default: r = 4'b0_000;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] char_value(input logic [2:0] base, input logic [7:0] c);
    logic [6:0] v;
    v = VAL_BAD;
    unique case (base[2:1])
      2'd0: begin
        if (c >= "0" && c <= "9") v = 7'(c - "0");
        else if (!base[0] && c >= "a" && c <= "f") v = 7'(c - "a" + 8'd10);
        else if (base[0] && c >= "A" && c <= "F") v = 7'(c - "A" + 8'd10);
      end
      2'd1: begin
        if (!base[0] && c >= "a" && c <= "z") v = 7'(c - "a");
        else if (base[0] && c >= "A" && c <= "Z") v = 7'(c - "A");
        else if (c >= "2" && c <= "7") v = 7'(c - "2" + 8'd26);
      end
      default: begin
        if (c >= "A" && c <= "Z") v = 7'(c - "A");
        else if (c >= "a" && c <= "z") v = 7'(c - "a" + 8'd26);
        else if (c >= "0" && c <= "9") v = 7'(c - "0" + 8'd52);
        else if (!base[1] && c == "+") v = 7'd62;
        else if (!base[1] && c == "/") v = 7'd63;
        else if (base[1] && c == "-") v = 7'd62;
        else if (base[1] && c == "_") v = 7'd63;
        else if (base[0] && c == "=") v = VAL_PAD;
      end
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/pbtd_core.sv @@
// Input register, per-character decode and group state; emits at most one result bundle per request.
module pbtd_core
  import pbtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_is_last,
  input  logic       q_space,
  output logic       push,
  output bundle_t    bundle
);

  logic        vld_r;
  logic [7:0]  char_r;
  logic        last_r;

  logic        exp_r, exp_nxt;
  logic        swl_r, swl_nxt;
  logic [2:0]  base_r, base_nxt;
  logic [39:0] g_r, g_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [5:0]  vbc_r, vbc_nxt;
  logic        pad_r, pad_nxt;

  logic        advance;
  logic [3:0]  pfx;
  logic [2:0]  bpc;
  logic [3:0]  glen;
  logic [6:0]  val;
  logic [39:0] g_shift;
  logic [39:0] g_new;
  logic [5:0]  vbc_new;
  logic        pad_new;
  logic [3:0]  cnt_new;
  logic [6:0]  fill;
  logic [6:0]  shamt;
  err_t        err;
  logic        stat;
  logic [2:0]  nbytes;
  logic [39:0] bytes;

  assign advance  = vld_r && q_space;
  assign in_stall = vld_r && !q_space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      char_r <= in_char_code;
      last_r <= in_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= 1'b1;
      swl_r  <= 1'b0;
      base_r <= 3'd0;
      g_r    <= 40'd0;
      cnt_r  <= 3'd0;
      vbc_r  <= 6'd0;
      pad_r  <= 1'b0;
    end else if (advance) begin
      exp_r  <= exp_nxt;
      swl_r  <= swl_nxt;
      base_r <= base_nxt;
      g_r    <= g_nxt;
      cnt_r  <= cnt_nxt;
      vbc_r  <= vbc_nxt;
      pad_r  <= pad_nxt;
    end
  end

  always_comb begin
    exp_nxt  = exp_r;
    swl_nxt  = swl_r;
    base_nxt = base_r;
    g_nxt    = g_r;
    cnt_nxt  = cnt_r;
    vbc_nxt  = vbc_r;
    pad_nxt  = pad_r;
    err      = ERR_OK;
    stat     = 1'b0;
    nbytes   = 3'd0;
    bytes    = 40'd0;

    pfx     = prefix_decode(char_r);
    bpc     = char_bits(base_r);
    glen    = group_len(base_r);
    val     = char_value(base_r, char_r);
    g_shift = 40'(g_r << bpc);
    cnt_new = {1'b0, cnt_r} + 4'd1;
    fill    = {3'b000, cnt_new} * {4'b0000, bpc};
    shamt   = 7'd40 - fill;
    g_new   = g_r;
    vbc_new = vbc_r;
    pad_new = pad_r;

    if (swl_r) begin
      if (last_r) begin
        swl_nxt = 1'b0;
        exp_nxt = 1'b1;
      end
    end else if (exp_r) begin
      g_nxt   = 40'd0;
      cnt_nxt = 3'd0;
      vbc_nxt = 6'd0;
      pad_nxt = 1'b0;
      exp_nxt = 1'b0;
      if (!pfx[3]) begin
        err = ERR_PREFIX;
      end else begin
        base_nxt = pfx[2:0];
        if (last_r) begin
          stat    = 1'b1;
          exp_nxt = 1'b1;
        end
      end
    end else begin
      if (val == VAL_BAD) begin
        err = ERR_CHAR;
      end else if (val == VAL_PAD && vbc_r == 6'd0) begin
        err = ERR_EXTRA_PAD;
      end else if (val == VAL_PAD) begin
        pad_new = 1'b1;
        g_new   = g_shift;
      end else if (pad_r) begin
        err = ERR_AFTER_PAD;
      end else begin
        vbc_new = vbc_r + {3'b000, bpc};
        g_new   = g_shift | {34'd0, val[5:0]};
      end
      if (err == ERR_OK) begin
        g_nxt   = g_new;
        cnt_nxt = cnt_new[2:0];
        vbc_nxt = vbc_new;
        pad_nxt = pad_new;
        if (cnt_new >= glen || last_r) begin
          if (cnt_new < glen && is_padded(base_r)) begin
            err = ERR_MISSING_PAD;
          end else begin
            nbytes = vbc_new[5:3];
            bytes  = 40'(g_new << shamt);
            if (vbc_new[2:0] >= bpc) err = ERR_UNUSED;
            g_nxt   = 40'd0;
            cnt_nxt = 3'd0;
            vbc_nxt = 6'd0;
          end
        end
        if (err == ERR_OK && last_r) begin
          stat    = 1'b1;
          exp_nxt = 1'b1;
          g_nxt   = 40'd0;
          cnt_nxt = 3'd0;
          vbc_nxt = 6'd0;
          pad_nxt = 1'b0;
        end
      end
    end

    if (err != ERR_OK) begin
      stat    = 1'b1;
      g_nxt   = 40'd0;
      cnt_nxt = 3'd0;
      vbc_nxt = 6'd0;
      pad_nxt = 1'b0;
      if (last_r) exp_nxt = 1'b1;
      else swl_nxt = 1'b1;
    end
  end

  assign bundle.bytes      = bytes;
  assign bundle.nbytes     = nbytes;
  assign bundle.has_status = stat;
  assign bundle.err        = err;
  assign push = advance && (stat || nbytes != 3'd0);

  a_not_both: assert property (@(posedge clk) disable iff (!rst_n) !(swl_r && exp_r))
    else $error("swallowing while expecting prefix");
  a_grp_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!exp_r && !swl_r) |-> ({1'b0, cnt_r} < group_len(base_r)))
    else $error("group count reached group length without flush");
  a_vbc_max: assert property (@(posedge clk) disable iff (!rst_n) vbc_r <= 6'd40)
    else $error("valid bit count above group size");

endmodule

@@ rtl/core/pbtd_outq.sv @@
// Result bundle queue and serializer: bytes first, then the status, if any, of each bundle.
module pbtd_outq
  import pbtd_pkg::*;
#(
  parameter int DEPTH = PBTD_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bundle_t    bundle,
  output logic       q_space,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_status,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_error_code,
  output logic       out_run_last
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t       q_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic [2:0]    idx_r;

  bundle_t       head;
  logic          is_stat;
  logic          step;
  logic          pop;
  logic [7:0]    byte_sel;

  assign head      = q_r[rd_r];
  assign out_valid = cnt_r != '0;
  assign is_stat   = idx_r == head.nbytes;
  assign out_run_last = head.has_status ? is_stat : (idx_r == head.nbytes - 3'd1);
  assign step      = out_valid && !out_stall;
  assign pop       = step && out_run_last;
  assign q_space   = (cnt_r < CW'(DEPTH)) || pop;

  always_comb begin
    case (idx_r)
      3'd0:    byte_sel = head.bytes[39:32];
      3'd1:    byte_sel = head.bytes[31:24];
      3'd2:    byte_sel = head.bytes[23:16];
      3'd3:    byte_sel = head.bytes[15:8];
      3'd4:    byte_sel = head.bytes[7:0];
      default: byte_sel = 8'd0;
    endcase
  end

  assign out_is_status  = is_stat;
  assign out_data_byte  = is_stat ? 8'd0 : byte_sel;
  assign out_error_code = is_stat ? head.err : ERR_OK;

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      idx_r <= 3'd0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop) begin
        rd_r  <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
        idx_r <= 3'd0;
      end else if (step) begin
        idx_r <= idx_r + 3'd1;
      end
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r <= head.nbytes))
    else $error("serializer index past bundle end");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (cnt_r < CW'(DEPTH)))
    else $error("push into full queue");

endmodule

@@ rtl/core/prefixed_base_text_decoder.sv @@
// Top level of the prefixed base16/base32/base64 text decoder.
// A result passes through the input register and then the bundle queue before it is output.
// Throughput: one character per cycle, and one result per cycle while out_stall is low; the
// character side stalls only when the QDEPTH-entry bundle queue is full.
// Reset: synchronous active-low rst_n; next character is a prefix, queue empties.
module prefixed_base_text_decoder
  import pbtd_pkg::*;
#(
  parameter int QDEPTH = PBTD_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_status,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_error_code,
  output logic       out_run_last
);

  logic    q_space;
  logic    push;
  bundle_t bundle;

  pbtd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .q_space      (q_space),
    .push         (push),
    .bundle       (bundle)
  );

  pbtd_outq #(
    .DEPTH (QDEPTH)
  ) u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .bundle         (bundle),
    .q_space        (q_space),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_status  (out_is_status),
    .out_data_byte  (out_data_byte),
    .out_error_code (out_error_code),
    .out_run_last   (out_run_last)
  );

endmodule
